@@ rtl/q4dp_pkg.sv @@
// Shared types and constants for the Q4 nibble dot product core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package q4dp_pkg;

  localparam int unsigned ACT_W   = 16;
  localparam int unsigned PROD_W  = 20;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned RES_W   = 48;
  localparam int unsigned SHIFT   = 12;
  localparam int unsigned MUL_W   = SUM_W + SCALE_W;

  localparam logic [4:0] NIBBLE_BIAS = 5'd8;
  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd4096;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_lo;
    logic signed [PROD_W-1:0] prod_hi;
    logic                     last;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/q4dp_fifo.sv @@
// Small register-based FIFO used between front, back and result ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module q4dp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] data_o,
  output      logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/q4dp_front.sv @@
// Front end: centers the nibbles, forms both products and queues them.
// Depends on q4dp_pkg and q4dp_fifo.
`timescale 1ns / 1ps
`default_nettype none

module q4dp_front #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push_i,
  output      logic                                full_o,
  input  wire logic [7:0]                          weight_byte_i,
  input  wire logic signed [q4dp_pkg::ACT_W-1:0]   act_first_i,
  input  wire logic signed [q4dp_pkg::ACT_W-1:0]   act_second_i,
  input  wire logic                                second_used_i,
  input  wire logic                                last_item_i,
  input  wire logic                                pop_i,
  output      q4dp_pkg::item_t                     item_o,
  output      logic                                empty_o
);

  logic signed [4:0]                     w_lo, w_hi;
  logic signed [q4dp_pkg::PROD_W-1:0]    full_lo, full_hi;
  q4dp_pkg::item_t                       item_in;
  logic [$bits(q4dp_pkg::item_t)-1:0]    item_out;

  assign w_lo    = $signed({1'b0, weight_byte_i[3:0]} - q4dp_pkg::NIBBLE_BIAS);
  assign w_hi    = $signed({1'b0, weight_byte_i[7:4]} - q4dp_pkg::NIBBLE_BIAS);
  assign full_lo = w_lo * act_first_i;
  assign full_hi = w_hi * act_second_i;

  always_comb begin
    item_in.prod_lo = full_lo;
    item_in.prod_hi = second_used_i ? full_hi : '0;
    item_in.last    = last_item_i;
  end

  q4dp_fifo #(
    .WIDTH($bits(q4dp_pkg::item_t)),
    .DEPTH(DEPTH)
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (item_in),
    .full_o (full_o),
    .pop_i  (pop_i),
    .data_o (item_out),
    .empty_o(empty_o)
  );

  assign item_o = q4dp_pkg::item_t'(item_out);

endmodule

`default_nettype wire

@@ rtl/q4dp_back.sv @@
// Back end: saturating accumulation, final scaling and result queue.
// Depends on q4dp_pkg and q4dp_fifo.
`timescale 1ns / 1ps
`default_nettype none

module q4dp_back #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire q4dp_pkg::item_t                      item_i,
  input  wire logic                                 item_empty_i,
  output      logic                                 item_pop_o,
  input  wire logic                                 scale_we_i,
  input  wire logic [q4dp_pkg::SCALE_W-1:0]         scale_i,
  input  wire logic                                 pop_i,
  output      logic                                 empty_o,
  output      logic signed [q4dp_pkg::RES_W-1:0]    dot_result_o
);

  localparam int unsigned SW = q4dp_pkg::SUM_W;
  localparam int unsigned MW = q4dp_pkg::MUL_W;
  localparam int unsigned RW = q4dp_pkg::RES_W;
  localparam int unsigned KEEP_W = MW - q4dp_pkg::SHIFT;

  logic signed [SW-1:0]                    run_q, run_d;
  logic signed [SW-1:0]                    fin_q;
  logic                                    fin_vld_q, fin_vld_d;
  logic signed [q4dp_pkg::SCALE_W-1:0]     scale_q;
  logic signed [SW:0]                      add1, add2;
  logic signed [SW-1:0]                    sat1, sat2;
  logic signed [MW-1:0]                    prod;
  logic signed [RW-1:0]                    res;
  logic                                    res_full, res_push, fin_free, take;
  logic [RW-1:0]                           res_out;

  function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW:0] v);
    if (v[SW] != v[SW-1]) begin
      sat_sum = v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sat_sum = v[SW-1:0];
    end
  endfunction

  assign add1 = {run_q[SW-1], run_q} + (SW+1)'(item_i.prod_lo);
  assign sat1 = sat_sum(add1);
  assign add2 = {sat1[SW-1], sat1} + (SW+1)'(item_i.prod_hi);
  assign sat2 = sat_sum(add2);

  assign res_push   = fin_vld_q;
  assign fin_free   = !fin_vld_q || !res_full;
  assign item_pop_o = !item_empty_i && (!item_i.last || fin_free);
  assign take       = item_pop_o;

  always_comb begin
    run_d     = run_q;
    fin_vld_d = fin_vld_q && res_full;
    if (take) begin
      if (item_i.last) begin
        run_d     = '0;
        fin_vld_d = 1'b1;
      end else begin
        run_d = sat2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= '0;
      fin_vld_q <= 1'b0;
      scale_q   <= q4dp_pkg::SCALE_RESET;
    end else begin
      run_q     <= run_d;
      fin_vld_q <= fin_vld_d;
      if (scale_we_i) begin
        scale_q <= $signed(scale_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      fin_q <= sat2;
    end
  end

  // Product shifted right by 12 is at most 40 bits, so no output clamp is needed.
  assign prod = fin_q * scale_q;
  assign res  = RW'(prod[MW-1:q4dp_pkg::SHIFT]) | {{(RW-KEEP_W){prod[MW-1]}}, {KEEP_W{1'b0}}};

  q4dp_fifo #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop_i),
    .data_o (res_out),
    .empty_o(empty_o)
  );

  assign dot_result_o = $signed(res_out);

endmodule

`default_nettype wire

@@ rtl/q4_nibble_dot_product_core.sv @@
// Result path: a last item's sum is registered in fin_q, then pushed into the result queue.
// Throughput: one item per cycle; each item is one transfer of the input queue.
// A last item waits while a full result queue still holds back the previous sum.
// Reset: all queues empty, running sum zero, weight_scale back to 4096 (1.0).
// Top level; depends on q4dp_pkg, q4dp_fifo, q4dp_front and q4dp_back.
`timescale 1ns / 1ps
`default_nettype none

module q4_nibble_dot_product_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output      logic                                full,
  input  wire logic [7:0]                          weight_byte_i,
  input  wire logic signed [q4dp_pkg::ACT_W-1:0]   act_first_i,
  input  wire logic signed [q4dp_pkg::ACT_W-1:0]   act_second_i,
  input  wire logic                                second_used_i,
  input  wire logic                                last_item_i,
  output      logic                                empty,
  input  wire logic                                pop,
  output      logic signed [q4dp_pkg::RES_W-1:0]   dot_result_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [q4dp_pkg::SCALE_W-1:0]        cfg_data_i
);

  q4dp_pkg::item_t item;
  logic            item_empty, item_pop;

  assign cfg_ready_o = 1'b1;

  q4dp_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .weight_byte_i(weight_byte_i),
    .act_first_i  (act_first_i),
    .act_second_i (act_second_i),
    .second_used_i(second_used_i),
    .last_item_i  (last_item_i),
    .pop_i        (item_pop),
    .item_o       (item),
    .empty_o      (item_empty)
  );

  q4dp_back #(
    .DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .scale_we_i  (cfg_valid_i && cfg_ready_o),
    .scale_i     (cfg_data_i),
    .pop_i       (pop),
    .empty_o     (empty),
    .dot_result_o(dot_result_o)
  );

endmodule

`default_nettype wire

@@ tb/q4dp_checker.sv @@
// Checker for q4_nibble_dot_product_core: watches the item, result and scale
// channels, predicts each dot product and compares it at the result transfer.
// Depends on q4dp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module q4dp_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push_i,
  input  wire logic                                full_i,
  input  wire logic [7:0]                          weight_byte_i,
  input  wire logic signed [q4dp_pkg::ACT_W-1:0]   act_first_i,
  input  wire logic signed [q4dp_pkg::ACT_W-1:0]   act_second_i,
  input  wire logic                                second_used_i,
  input  wire logic                                last_item_i,
  input  wire logic                                empty_i,
  input  wire logic                                pop_i,
  input  wire logic signed [q4dp_pkg::RES_W-1:0]   dot_result_i,
  input  wire logic                                cfg_valid_i,
  input  wire logic                                cfg_ready_i,
  input  wire logic [q4dp_pkg::SCALE_W-1:0]        cfg_data_i,
  output      int                                  fail_count_o,
  output      int                                  pending_o,
  output      int                                  dots_checked_o
);

  localparam int     RES_BITS = q4dp_pkg::RES_W;
  localparam longint SUM_HI = (longint'(1) <<< (q4dp_pkg::SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint RES_HI = (longint'(1) <<< (q4dp_pkg::RES_W - 1)) - 1;
  localparam longint RES_LO = -RES_HI - 1;

  logic signed [q4dp_pkg::RES_W-1:0]   expected_dot_q[$];
  logic signed [q4dp_pkg::SCALE_W-1:0] scale_reg = q4dp_pkg::SCALE_RESET;
  longint                              acc_sum = 0;
  int                                  mismatches = 0;
  int                                  waiting = 0;
  int                                  checked = 0;

  assign fail_count_o   = mismatches;
  assign pending_o      = waiting;
  assign dots_checked_o = checked;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: dot_result %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic accumulate_item();
    longint w_lo;
    longint w_hi;
    longint s;
    longint scaled;
    w_lo = longint'(weight_byte_i[3:0]) - longint'(q4dp_pkg::NIBBLE_BIAS);
    w_hi = longint'(weight_byte_i[7:4]) - longint'(q4dp_pkg::NIBBLE_BIAS);
    s = clip(acc_sum + w_lo * longint'(act_first_i), SUM_LO, SUM_HI);
    if (second_used_i) begin
      s = clip(s + w_hi * longint'(act_second_i), SUM_LO, SUM_HI);
    end
    if (!last_item_i) begin
      acc_sum = s;
    end else begin
      // floor shift: arithmetic shift of a signed product
      scaled = (s * longint'(scale_reg)) >>> q4dp_pkg::SHIFT;
      expected_dot_q.push_back(RES_BITS'(clip(scaled, RES_LO, RES_HI)));
      acc_sum = 0;
    end
  endtask

  task automatic check_dot();
    logic signed [q4dp_pkg::RES_W-1:0] want;
    if (expected_dot_q.size() == 0) begin
      report_mismatch("transfer with nothing pending", longint'(dot_result_i), 0);
    end else begin
      want = expected_dot_q.pop_front();
      if (dot_result_i !== want) begin
        report_mismatch("mismatch", longint'(dot_result_i), longint'(want));
      end
      checked++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_sum = 0;
      scale_reg = q4dp_pkg::SCALE_RESET;
      expected_dot_q.delete();
    end else begin
      if (pop_i && !empty_i) check_dot();
      if (cfg_valid_i && cfg_ready_i) scale_reg = cfg_data_i;
      if (push_i && !full_i) accumulate_item();
    end
    waiting = expected_dot_q.size();
  end

endmodule

`default_nettype wire

@@ tb/tb_q4_nibble_dot_product_core.sv @@
// Testbench top for q4_nibble_dot_product_core: directed and random vectors,
// scale changes between phases, stalls on both queues; q4dp_checker judges.
// Depends on q4dp_pkg, q4dp_checker and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_q4_nibble_dot_product_core;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                push = 1'b0;
  logic                                full;
  logic [7:0]                          weight_byte = '0;
  logic signed [q4dp_pkg::ACT_W-1:0]   act_first = '0;
  logic signed [q4dp_pkg::ACT_W-1:0]   act_second = '0;
  logic                                second_used = 1'b0;
  logic                                last_item = 1'b0;
  logic                                empty;
  logic                                pop = 1'b0;
  logic signed [q4dp_pkg::RES_W-1:0]   dot_result;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [q4dp_pkg::SCALE_W-1:0]        cfg_data = '0;

  int  fail_count;
  int  pending;
  int  dots_checked;
  int  items_sent = 0;
  int  scale_writes = 0;
  int  results_taken = 0;
  bit  sender_gaps = 1'b1;

  always #4 clk_i = ~clk_i;

  q4_nibble_dot_product_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .weight_byte_i (weight_byte),
    .act_first_i   (act_first),
    .act_second_i  (act_second),
    .second_used_i (second_used),
    .last_item_i   (last_item),
    .empty         (empty),
    .pop           (pop),
    .dot_result_o  (dot_result),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  q4dp_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .weight_byte_i  (weight_byte),
    .act_first_i    (act_first),
    .act_second_i   (act_second),
    .second_used_i  (second_used),
    .last_item_i    (last_item),
    .empty_i        (empty),
    .pop_i          (pop),
    .dot_result_i   (dot_result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .dots_checked_o (dots_checked)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [q4dp_pkg::ACT_W-1:0] pick_act();
    case ($urandom_range(0, 19))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return '1;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_item(input logic [7:0] wb, input logic signed [15:0] a0,
                           input logic signed [15:0] a1, input logic used,
                           input logic lst);
    int gap;
    @(negedge clk_i);
    push        <= 1'b1;
    weight_byte <= wb;
    act_first   <= a0;
    act_second  <= a1;
    second_used <= used;
    last_item   <= lst;
    do @(posedge clk_i); while (full);
    items_sent++;
    gap = sender_gaps ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // lower push, wait for every dot product, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_scale(input logic [q4dp_pkg::SCALE_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    scale_writes++;
  endtask

  task automatic run_random_vectors(input int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 4);
      else if (r < 95) len = $urandom_range(5, 16);
      else             len = $urandom_range(17, 64);
      for (int k = 0; k < len; k++) begin
        send_item(8'($urandom()), pick_act(), pick_act(), $urandom_range(0, 4) != 0,
                  k == len - 1);
      end
      sent += len;
    end
  endtask

  // result side: random stalls, stall-free stretches, two long hold-offs
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        results_taken++;
        if (results_taken == 40 || results_taken == 150) stall = LONG_HOLD;
        else if ((results_taken / 50) % 3 == 0) stall = 0;
        else stall = idle_len();
      end else if (!pop && stall > 0) begin
        stall--;
      end
      @(negedge clk_i);
      pop <= (stall == 0) && rst_ni;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset scale 1.0: weight extremes, zero weights, unused high nibble
    send_item(8'h00, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
    send_item(8'hFF, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1);
    send_item(8'h88, 16'sh04D2, -16'sh04D2, 1'b1, 1'b1);
    send_item(8'h0F, 16'sh0064, 16'sh8000, 1'b0, 1'b1);
    send_item(8'h3C, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
    send_item(8'hA5, 16'sh1234, 16'sh8000, 1'b0, 1'b0);
    send_item(8'h7E, -16'sh0100, 16'sh0200, 1'b1, 1'b0);
    send_item(8'h91, 16'sh0300, 16'sh7FFF, 1'b0, 1'b1);

    // floor rounding of small sums at tiny scales
    write_scale(16'h0001);
    send_item(8'h09, 16'sh0001, 16'sh0000, 1'b0, 1'b1);
    send_item(8'h07, 16'sh0001, 16'sh0000, 1'b0, 1'b1);
    write_scale(16'hFFFF);
    send_item(8'h09, 16'sh0001, 16'sh0000, 1'b0, 1'b1);
    send_item(8'h07, 16'sh0003, 16'sh0000, 1'b0, 1'b1);

    write_scale(16'h8000);
    send_item(8'h00, 16'sh8000, 16'sh8000, 1'b1, 1'b1);
    write_scale(16'h7FFF);
    send_item(8'hFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
    write_scale(16'h0000);
    send_item(8'h5A, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);

    write_scale(16'h8000);
    run_random_vectors(320);
    write_scale(16'h7FFF);
    run_random_vectors(320);
    write_scale(16'($urandom()));
    run_random_vectors(320);
    write_scale(16'h1000);
    sender_gaps = 1'b0;
    run_random_vectors(320);
    sender_gaps = 1'b1;
    write_scale(16'($urandom()));
    run_random_vectors(320);

    drain_results();
    $display("Coverage: %0d items sent, %0d dot products checked, %0d scale writes",
             items_sent, dots_checked, scale_writes);
    $display("Included rounding at tiny scales, scale extremes and long result stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("[q4_nibble_dot_product_core] OK");
    end else begin
      $display("[q4_nibble_dot_product_core] ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timeout: %0d dot products still pending", pending);
    $display("[q4_nibble_dot_product_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
